// ===== rtl/rgb565_pixel_compositor_top_macros.svh =====
// assertion macros for the compositor
`ifndef RGB565_PIXEL_COMPOSITOR_TOP_MACROS_SVH
`define RGB565_PIXEL_COMPOSITOR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rpc_pkg.sv =====
package rpc_pkg;

  localparam int PIX_W      = 16;
  localparam int CH_W       = 6;
  localparam int NUM_CH     = 3;
  localparam int COV_W      = 8;
  localparam int CMD_W      = 2;
  localparam int MULT_W     = 9;
  localparam int STR_W      = 8;
  localparam int PROD_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_ALPHA = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TINT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MULT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_COLOR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_STRENGTH = 2'd2;

  localparam logic [MULT_W-1:0] ALPHA_MULT_RESET    = 9'd256;
  localparam logic [PIX_W-1:0]  TINT_COLOR_RESET    = 16'hFFFF;
  localparam logic [STR_W-1:0]  TINT_STRENGTH_RESET = 8'd170;

  localparam logic [COV_W-1:0] COV_FULL = 8'd255;
  localparam logic [CH_W-1:0]  CH_MAX_G  = 6'd63;
  localparam logic [CH_W-1:0]  CH_MAX_RB = 6'd31;
  localparam int               LANE_G    = 1;

  typedef logic [CH_W-1:0] chan_t;
  typedef chan_t [NUM_CH-1:0] chans_t;   // [2] red, [1] green, [0] blue
  typedef logic [PROD_W-1:0] prod_t;
  typedef prod_t [NUM_CH-1:0] prods_t;

  typedef struct packed {
    logic [MULT_W-1:0] alpha_mult;
    logic [PIX_W-1:0]  tint_color;
    logic [STR_W-1:0]  tint_strength;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [PIX_W-1:0] dst;
    logic [PIX_W-1:0] src;
    logic [COV_W-1:0] cov;
  } pix_in_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             we;
    logic             copy;
    chans_t           dst;
    chans_t           src;
    chans_t           tint;
    logic [COV_W-1:0] cov;
    logic [COV_W-1:0] a_fade;
  } s1_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             we;
    logic             copy;
    chans_t           dst;
    chans_t           src;
    prods_t           blend_prod;
    chans_t           add_part;
  } s2_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             we;
  } res_t;

  function automatic chans_t unpack_pix(input logic [PIX_W-1:0] p);
    chans_t c;
    c[2] = {1'b0, p[15:11]};
    c[1] = p[10:5];
    c[0] = {1'b0, p[4:0]};
    return c;
  endfunction

  function automatic logic [PIX_W-1:0] pack_pix(input chans_t c);
    return {c[2][4:0], c[1], c[0][4:0]};
  endfunction

endpackage

// ===== rtl/rpc_stage_pre.sv =====
module rpc_stage_pre
  import rpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  pix_in_t in_word,
  output logic    out_valid,
  input  logic    out_ready,
  output s1_t     out_word
);

  logic                     valid;
  s1_t                      word;
  s1_t                      word_next;
  chans_t                   src_ch;
  chans_t                   tint_ch;
  logic signed [CH_W:0]     tdiff   [NUM_CH];
  logic signed [PROD_W-1:0] tprod   [NUM_CH];
  logic [7:0]               tsum    [NUM_CH];
  logic [2*COV_W-1:0]       fade_p;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_word  = word;

  // tint pull of the source and coverage fade
  always_comb begin
    src_ch  = unpack_pix(in_word.src);
    tint_ch = unpack_pix(cfg.tint_color);
    for (int i = 0; i < NUM_CH; i++) begin
      tdiff[i] = $signed({1'b0, tint_ch[i]}) - $signed({1'b0, src_ch[i]});
      tprod[i] = PROD_W'(tdiff[i]) * PROD_W'($signed({1'b0, cfg.tint_strength}));
      tsum[i]  = {2'b00, src_ch[i]} + tprod[i][15:8];
    end
    fade_p = (2*COV_W)'(in_word.cov) * (2*COV_W)'(cfg.alpha_mult[7:0]);

    word_next.cmd  = in_word.cmd;
    word_next.dst  = unpack_pix(in_word.dst);
    word_next.src  = src_ch;
    for (int i = 0; i < NUM_CH; i++) begin
      word_next.tint[i] = tsum[i][CH_W-1:0];
    end
    word_next.cov    = in_word.cov;
    word_next.a_fade = cfg.alpha_mult[8] ? in_word.cov : fade_p[2*COV_W-1:COV_W];
    word_next.copy   = (in_word.cmd == CMD_ALPHA) && cfg.alpha_mult[8]
                       && (in_word.cov == COV_FULL);
    if (in_word.cmd == CMD_ALPHA || in_word.cmd == CMD_TINT) begin
      word_next.we = (in_word.cov != '0);
    end else begin
      word_next.we = (in_word.cmd == CMD_ADD);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word <= word_next;
    end
  end

endmodule

// ===== rtl/rpc_stage_mul.sv =====
module rpc_stage_mul
  import rpc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  s1_t  in_word,
  output logic out_valid,
  input  logic out_ready,
  output s2_t  out_word
);

  logic                     valid;
  s2_t                      word;
  s2_t                      word_next;
  chans_t                   sel_src;
  logic [COV_W-1:0]         sel_a;
  logic signed [CH_W:0]     bdiff  [NUM_CH];
  logic [CH_W+COV_W-1:0]    addp   [NUM_CH];

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_word  = word;

  // blend and additive products per channel
  always_comb begin
    sel_src = (in_word.cmd == CMD_TINT) ? in_word.tint : in_word.src;
    sel_a   = (in_word.cmd == CMD_ALPHA) ? in_word.a_fade : in_word.cov;
    word_next.cmd  = in_word.cmd;
    word_next.we   = in_word.we;
    word_next.copy = in_word.copy;
    word_next.dst  = in_word.dst;
    word_next.src  = in_word.src;
    for (int i = 0; i < NUM_CH; i++) begin
      bdiff[i] = $signed({1'b0, sel_src[i]}) - $signed({1'b0, in_word.dst[i]});
      word_next.blend_prod[i] = PROD_W'(bdiff[i]) * PROD_W'($signed({1'b0, sel_a}));
      addp[i] = (CH_W+COV_W)'(in_word.src[i]) * (CH_W+COV_W)'(in_word.cov);
      word_next.add_part[i] = addp[i][CH_W+COV_W-1:COV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word <= word_next;
    end
  end

endmodule

// ===== rtl/rpc_stage_out.sv =====
module rpc_stage_out
  import rpc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  s2_t  in_word,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_word
);

  logic       valid;
  res_t       word;
  res_t       word_next;
  chans_t     blend_ch;
  chans_t     add_ch;
  logic [7:0] bsum [NUM_CH];
  logic [CH_W:0] asum [NUM_CH];
  chan_t      top;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_word  = word;

  // final add, saturation and mode select
  always_comb begin
    top = CH_MAX_RB;
    for (int i = 0; i < NUM_CH; i++) begin
      bsum[i]     = {2'b00, in_word.dst[i]} + in_word.blend_prod[i][15:8];
      blend_ch[i] = bsum[i][CH_W-1:0];
      asum[i]     = {1'b0, in_word.dst[i]} + {1'b0, in_word.add_part[i]};
      top         = (i == LANE_G) ? CH_MAX_G : CH_MAX_RB;
      add_ch[i]   = (asum[i] > {1'b0, top}) ? top : asum[i][CH_W-1:0];
    end
    word_next.we = in_word.we;
    priority if (!in_word.we) begin
      word_next.pixel = pack_pix(in_word.dst);
    end else if (in_word.cmd == CMD_ADD) begin
      word_next.pixel = pack_pix(add_ch);
    end else if (in_word.copy) begin
      word_next.pixel = pack_pix(in_word.src);
    end else begin
      word_next.pixel = pack_pix(blend_ch);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word <= word_next;
    end
  end

endmodule

// ===== rtl/rgb565_pixel_compositor_top.sv =====
// RGB565 pixel compositor: one word in and one word out per clock when the output is not
// stalled, each accepted word registered in turn in every stage. The stages are the
// tint pull and coverage fade, the per-channel blend and add products, then the final
// add with saturation and mode select; each stage holds its word under backpressure, so
// a stall loses nothing and the pipeline keeps three words in flight. cmd 0 blends with
// coverage faded by alpha_multiplier (256 means no fade, full coverage copies the
// source), cmd 1 pulls the source toward tint_color by tint_strength and then blends,
// cmd 2 adds the scaled source with saturation. Zero coverage in cmd 0 or 1, and cmd 3,
// give write_enable low with out_pixel equal to dst_pixel. Registers must be written
// only while no word is in flight; the block itself does not enforce this.
`include "rgb565_pixel_compositor_top_macros.svh"

module rgb565_pixel_compositor_top
  import rpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [PIX_W-1:0]      dst_pixel,
  input  logic [PIX_W-1:0]      src_pixel,
  input  logic [COV_W-1:0]      coverage,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_pixel,
  output logic                  write_enable
);

  cfg_t    cfg;
  pix_in_t in_word;
  s1_t     s1_word;
  s2_t     s2_word;
  res_t    res_word;
  logic    s1_valid;
  logic    s1_ready;
  logic    s2_valid;
  logic    s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha_mult    <= ALPHA_MULT_RESET;
      cfg.tint_color    <= TINT_COLOR_RESET;
      cfg.tint_strength <= TINT_STRENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA_MULT:    cfg.alpha_mult    <= cfg_data[MULT_W-1:0];
        REG_TINT_COLOR:    cfg.tint_color    <= cfg_data[PIX_W-1:0];
        REG_TINT_STRENGTH: cfg.tint_strength <= cfg_data[STR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_word.cmd = cmd;
  assign in_word.dst = dst_pixel;
  assign in_word.src = src_pixel;
  assign in_word.cov = coverage;

  rpc_stage_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_word  (s1_word)
  );

  rpc_stage_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_word   (s1_word),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_word  (s2_word)
  );

  rpc_stage_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_word   (s2_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (res_word)
  );

  assign out_pixel    = res_word.pixel;
  assign write_enable = res_word.we;

  // input stalls only when every stage is full and the output is held
  `RPC_ASSERT_NOW(a_stall_only_when_full, !in_ready,
    s1_valid && s2_valid && out_valid && !out_ready, "input stalled with room in pipe")
  // an accepted word lands in the first stage
  `RPC_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, s1_valid,
    "accepted word lost at first stage")
  // a held result keeps its value
  `RPC_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
    out_valid && $stable(out_pixel) && $stable(write_enable), "held result changed")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import rpc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;
  localparam int FADE_NONE = 256;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 142;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    pix_in_t               w;
    bit                    known;
    res_t                  want;
  } plan_row_t;

  typedef struct {
    bit   known;
    res_t want;
  } hint_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      cmd = '0;
  logic [PIX_W-1:0]      dst_pixel = '0;
  logic [PIX_W-1:0]      src_pixel = '0;
  logic [COV_W-1:0]      coverage = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_pixel;
  logic                  write_enable;

  // register copies used for prediction
  logic [MULT_W-1:0] fade_mult = ALPHA_MULT_RESET;
  logic [PIX_W-1:0]  tint_rgb = TINT_COLOR_RESET;
  logic [STR_W-1:0]  tint_pull = TINT_STRENGTH_RESET;

  hint_t   hint_q[$];
  res_t    result_q[$];
  hint_t   hint;
  pix_in_t acc;
  res_t    want;
  int      sent_count = 0;
  int      checked_count = 0;
  int      fail_count = 0;
  int      in_idle_pct = 0;
  int      out_stall_pct = 0;

  rgb565_pixel_compositor_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .dst_pixel    (dst_pixel),
    .src_pixel    (src_pixel),
    .coverage     (coverage),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel    (out_pixel),
    .write_enable (write_enable)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // d + floor((s - d) * a / 256)
  function automatic int mix_chan(int d, int s, int a);
    return d + (((s - d) * a) >>> 8);
  endfunction

  function automatic logic [PIX_W-1:0] mix_pixel(logic [PIX_W-1:0] d, logic [PIX_W-1:0] s,
                                                 int a);
    int r, g, b;
    r = mix_chan(d[15:11], s[15:11], a);
    g = mix_chan(d[10:5], s[10:5], a);
    b = mix_chan(d[4:0], s[4:0], a);
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  function automatic int add_chan(int d, int s, int a, int top);
    int v;
    v = d + ((s * a) >> 8);
    return (v > top) ? top : v;
  endfunction

  function automatic logic [PIX_W-1:0] add_pixel(logic [PIX_W-1:0] d, logic [PIX_W-1:0] s,
                                                 int a);
    int r, g, b;
    r = add_chan(d[15:11], s[15:11], a, CH_MAX_RB);
    g = add_chan(d[10:5], s[10:5], a, CH_MAX_G);
    b = add_chan(d[4:0], s[4:0], a, CH_MAX_RB);
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  function automatic res_t composite(pix_in_t w);
    res_t r;
    int   a;
    r.pixel = w.dst;
    r.we = 1'b0;
    case (w.cmd)
      CMD_ALPHA: begin
        if (w.cov != 0) begin
          a = w.cov;
          if (fade_mult < FADE_NONE) a = (a * fade_mult) >> 8;
          r.pixel = (a >= COV_FULL) ? w.src : mix_pixel(w.dst, w.src, a);
          r.we = 1'b1;
        end
      end
      CMD_TINT: begin
        if (w.cov != 0) begin
          r.pixel = mix_pixel(w.dst, mix_pixel(w.src, tint_rgb, tint_pull), w.cov);
          r.we = 1'b1;
        end
      end
      CMD_ADD: begin
        r.pixel = add_pixel(w.dst, w.src, w.cov);
        r.we = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic pix_in_t random_word();
    pix_in_t w;
    int      pick;
    pick = $urandom_range(0, 15);
    if (pick < 5) w.cmd = CMD_ALPHA;
    else if (pick < 10) w.cmd = CMD_TINT;
    else if (pick < 15) w.cmd = CMD_ADD;
    else w.cmd = CMD_UNDEF;
    w.dst = random_pixel();
    w.src = random_pixel();
    case ($urandom_range(0, 9))
      0: w.cov = '0;
      1: w.cov = COV_FULL;
      2: w.cov = 8'd1;
      3: w.cov = 8'd254;
      default: w.cov = COV_W'($urandom);
    endcase
    return w;
  endfunction

  function automatic plan_row_t item_row(logic [CMD_W-1:0] c, logic [PIX_W-1:0] d,
                                         logic [PIX_W-1:0] s, logic [COV_W-1:0] a);
    plan_row_t row;
    row.is_reg = 1'b0;
    row.idx = '0;
    row.data = '0;
    row.w = '{cmd: c, dst: d, src: s, cov: a};
    row.known = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t fixed_row(logic [CMD_W-1:0] c, logic [PIX_W-1:0] d,
                                          logic [PIX_W-1:0] s, logic [COV_W-1:0] a,
                                          logic [PIX_W-1:0] p, logic we);
    plan_row_t row;
    row = item_row(c, d, s, a);
    row.known = 1'b1;
    row.want = '{pixel: p, we: we};
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] v);
    plan_row_t row;
    row = item_row(CMD_ALPHA, '0, '0, '0);
    row.is_reg = 1'b1;
    row.idx = i;
    row.data = v;
    return row;
  endfunction

  task automatic send_word(pix_in_t w, bit known, res_t expect_word);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= w.cmd;
    dst_pixel <= w.dst;
    src_pixel <= w.src;
    coverage <= w.cov;
    hint_q.push_back('{known, expect_word});
    sent_count++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (checked_count != sent_count) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic note_fail(string what, logic [PIX_W:0] exp_val, logic [PIX_W:0] act_val);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("mismatch on %s at %0t: expected %h, got %h", what, $time, exp_val, act_val);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      fade_mult = ALPHA_MULT_RESET;
      tint_rgb = TINT_COLOR_RESET;
      tint_pull = TINT_STRENGTH_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ALPHA_MULT: fade_mult = cfg_data[MULT_W-1:0];
          REG_TINT_COLOR: tint_rgb = cfg_data[PIX_W-1:0];
          REG_TINT_STRENGTH: tint_pull = cfg_data[STR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        hint = hint_q.pop_front();
        acc.cmd = cmd;
        acc.dst = dst_pixel;
        acc.src = src_pixel;
        acc.cov = coverage;
        result_q.push_back(hint.known ? hint.want : composite(acc));
      end
      if (out_valid && out_ready) begin
        checked_count++;
        if (result_q.size() == 0) begin
          note_fail("unexpected word", '0, {write_enable, out_pixel});
        end else begin
          want = result_q.pop_front();
          if (out_pixel !== want.pixel)
            note_fail("out_pixel", {1'b0, want.pixel}, {1'b0, out_pixel});
          if (write_enable !== want.we)
            note_fail("write_enable", {{PIX_W{1'b0}}, want.we}, {{PIX_W{1'b0}}, write_enable});
        end
      end
    end
  end

  initial begin
    plan_row_t plan[$];
    int        fade_list[5];
    int        tint_list[5];
    int        pull_list[5];
    pix_in_t   w;

    fade_list = '{256, 0, 256, 1, 255};
    tint_list = '{32'hFFFF, 32'h0000, 32'hF800, 32'h07E0, 32'h001F};
    pull_list = '{170, 0, 255, 1, 128};

    // reset settings: no fade, white tint
    plan.push_back(fixed_row(CMD_ALPHA, 16'h1234, 16'hABCD, 8'd0, 16'h1234, 1'b0));
    plan.push_back(fixed_row(CMD_ALPHA, 16'h0000, 16'hFFFF, COV_FULL, 16'hFFFF, 1'b1));
    plan.push_back(fixed_row(CMD_ALPHA, 16'hFFFF, 16'h0000, COV_FULL, 16'h0000, 1'b1));
    plan.push_back(item_row(CMD_ALPHA, 16'h0000, 16'hFFFF, 8'd1));
    plan.push_back(item_row(CMD_ALPHA, 16'hFFFF, 16'h0000, 8'd128));
    plan.push_back(item_row(CMD_ALPHA, 16'hF81F, 16'h07E0, 8'd254));
    plan.push_back(fixed_row(CMD_TINT, 16'hABCD, 16'h1234, 8'd0, 16'hABCD, 1'b0));
    plan.push_back(item_row(CMD_TINT, 16'h0000, 16'h0000, COV_FULL));
    plan.push_back(fixed_row(CMD_TINT, 16'hFFFF, 16'hFFFF, COV_FULL, 16'hFFFF, 1'b1));
    plan.push_back(fixed_row(CMD_ADD, 16'h5555, 16'hFFFF, 8'd0, 16'h5555, 1'b1));
    plan.push_back(fixed_row(CMD_ADD, 16'hFFFF, 16'hFFFF, COV_FULL, 16'hFFFF, 1'b1));
    plan.push_back(item_row(CMD_ADD, 16'h0000, 16'hFFFF, COV_FULL));
    plan.push_back(item_row(CMD_ADD, 16'h8410, 16'h8410, 8'd128));
    plan.push_back(fixed_row(CMD_UNDEF, 16'h2468, 16'hFFFF, COV_FULL, 16'h2468, 1'b0));
    plan.push_back(fixed_row(CMD_UNDEF, 16'hFFFF, 16'h0000, 8'd0, 16'hFFFF, 1'b0));
    // fade down to zero still writes dst
    plan.push_back(reg_row(REG_ALPHA_MULT, 16'd1));
    plan.push_back(fixed_row(CMD_ALPHA, 16'h3C3C, 16'hFFFF, COV_FULL, 16'h3C3C, 1'b1));
    plan.push_back(reg_row(REG_ALPHA_MULT, 16'd0));
    plan.push_back(fixed_row(CMD_ALPHA, 16'h0000, 16'hFFFF, COV_FULL, 16'h0000, 1'b1));
    plan.push_back(reg_row(REG_ALPHA_MULT, 16'd255));
    plan.push_back(item_row(CMD_ALPHA, 16'h0000, 16'hFFFF, COV_FULL));
    // tint mode has no copy at full coverage
    plan.push_back(reg_row(REG_TINT_COLOR, 16'h0000));
    plan.push_back(reg_row(REG_TINT_STRENGTH, 16'd0));
    plan.push_back(item_row(CMD_TINT, 16'h0000, 16'hFFFF, COV_FULL));
    plan.push_back(reg_row(REG_TINT_COLOR, 16'h001F));
    plan.push_back(reg_row(REG_TINT_STRENGTH, 16'd255));
    plan.push_back(item_row(CMD_TINT, 16'hFFFF, 16'h0000, 8'd128));
    plan.push_back(item_row(CMD_TINT, 16'h0000, 16'h0000, 8'd1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].idx, plan[i].data);
      else send_word(plan[i].w, plan[i].known, plan[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p % 4)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 58; out_stall_pct = 0; end
        2: begin in_idle_pct = 0; out_stall_pct = 58; end
        default: begin in_idle_pct = 28; out_stall_pct = 28; end
      endcase
      if (p < 5) begin
        write_reg(REG_ALPHA_MULT, CFG_DATA_W'(fade_list[p]));
        write_reg(REG_TINT_COLOR, CFG_DATA_W'(tint_list[p]));
        write_reg(REG_TINT_STRENGTH, CFG_DATA_W'(pull_list[p]));
      end else begin
        write_reg(REG_ALPHA_MULT, CFG_DATA_W'($urandom_range(0, 256)));
        write_reg(REG_TINT_COLOR, CFG_DATA_W'($urandom));
        write_reg(REG_TINT_STRENGTH, CFG_DATA_W'($urandom_range(0, 255)));
      end
      repeat (WORDS_PER_PHASE) begin
        w = random_word();
        send_word(w, 1'b0, '0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (result_q.size() != 0) begin
      fail_count += result_q.size();
      $display("%0d expected words never arrived", result_q.size());
    end
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rpc_pkg.sv
rtl/rpc_stage_pre.sv
rtl/rpc_stage_mul.sv
rtl/rpc_stage_out.sv
rtl/rgb565_pixel_compositor_top.sv
test/testbench.sv
